/* hw/rtl/tlba_pkg.sv */
`default_nettype none

package tlba_pkg;

  // Field widths
  localparam int unsigned PAGE_W  = 4;
  localparam int unsigned BLK_W   = 5;
  localparam int unsigned NBLK_W  = 6;
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned CFG_W   = 32;

  // Parameter defaults
  localparam int unsigned PAGES_DEFAULT      = 16;
  localparam int unsigned MAX_BLOCKS_DEFAULT = 32;

  // Register reset values
  localparam logic [NBLK_W-1:0] BPP_RESET   = NBLK_W'(32);
  localparam logic [SIZE_W-1:0] BSIZE_RESET = SIZE_W'(4096);

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NO_SPACE     = 3'd1,
    ST_TOO_LARGE    = 3'd2,
    ST_BAD_INDEX    = 3'd3,
    ST_ALREADY_FREE = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    CFG_BLOCKS_PER_PAGE = 1'b0,
    CFG_BLOCK_SIZE      = 1'b1
  } cfg_idx_e;

  // Page word memory request
  typedef struct packed {
    logic              rd_en;
    logic [PAGE_W-1:0] rd_addr;
    logic              wr_en;
    logic [PAGE_W-1:0] wr_addr;
  } mem_ctl_t;

  typedef struct packed {
    status_e          status;
    logic [PAGE_W-1:0] grant_page;
    logic [BLK_W-1:0]  grant_block;
    logic              page_claimed;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/tlba_map_mem.sv */
`default_nettype none

module tlba_map_mem
  import tlba_pkg::*;
#(
  parameter int unsigned PAGES      = PAGES_DEFAULT,
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEFAULT
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire mem_ctl_t              ctl_i,
  input  wire logic [MAX_BLOCKS-1:0] wr_data_i,
  output logic      [MAX_BLOCKS-1:0] rd_data_o
);

  localparam int unsigned PIDX_W = (PAGES > 1) ? $clog2(PAGES) : 1;

  logic [MAX_BLOCKS-1:0] mem [PAGES];
  logic [PAGES-1:0]      vld_q;
  logic [MAX_BLOCKS-1:0] rdata_q;
  logic                  rvld_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[ctl_i.wr_addr[PIDX_W-1:0]] <= wr_data_i;
    end
    // Hold read data until the next read
    if (ctl_i.rd_en) begin
      rdata_q <= mem[ctl_i.rd_addr[PIDX_W-1:0]];
    end
  end

  // Per-page written marks stand in for clearing the words at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (ctl_i.wr_en) begin
        vld_q[ctl_i.wr_addr[PIDX_W-1:0]] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rvld_q <= vld_q[ctl_i.rd_addr[PIDX_W-1:0]];
      end
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

/* hw/rtl/tlba_ctrl.sv */
`default_nettype none

module tlba_ctrl
  import tlba_pkg::*;
#(
  parameter int unsigned PAGES      = PAGES_DEFAULT,
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEFAULT
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  cmd_i,
  input  wire logic [SIZE_W-1:0]     req_size_i,
  input  wire logic [SIZE_W-1:0]     req_align_i,
  input  wire logic [PAGE_W-1:0]     free_page_i,
  input  wire logic [BLK_W-1:0]      free_block_i,
  input  wire logic [NBLK_W-1:0]     nblk_i,
  input  wire logic [SIZE_W-1:0]     block_size_i,
  input  wire logic                  out_ready_i,
  output logic                       res_valid_o,
  output res_t                       res_o,
  output mem_ctl_t                   mem_ctl_o,
  output logic      [MAX_BLOCKS-1:0] mem_wr_data_o,
  input  wire logic [MAX_BLOCKS-1:0] mem_rd_data_i
);

  localparam int unsigned PIDX_W = (PAGES > 1) ? $clog2(PAGES) : 1;

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } state_e;

  typedef enum logic [1:0] {
    OP_REJECT,
    OP_SCAN,
    OP_CLAIM,
    OP_FREE
  } op_e;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  status_e           rej_q, rej_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [BLK_W-1:0]  blk_q, blk_d;
  logic [PAGES-1:0]  avail_q, avail_d;
  logic [PAGES-1:0]  in_use_q, in_use_d;
  logic [PAGES-1:0]  full_q, full_d;

  logic [MAX_BLOCKS-1:0] lmask;
  logic [MAX_BLOCKS-1:0] free_bits;
  logic [MAX_BLOCKS-1:0] new_word;
  logic [MAX_BLOCKS-1:0] blk_bit;
  logic [BLK_W-1:0]      free_blk;
  logic [PAGES-1:0]      avail_now;
  logic [PAGES-1:0]      unclaimed;
  logic [PAGE_W-1:0]     first_pg;
  logic [PAGE_W-1:0]     next_pg;
  logic [PAGE_W-1:0]     claim_pg;
  logic                  too_large;
  logic                  bad_index;

  always_comb begin
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      lmask[i] = (NBLK_W'(i) < nblk_i);
    end
  end

  assign avail_now = in_use_q & ~full_q;
  assign unclaimed = ~in_use_q;
  assign free_bits = ~mem_rd_data_i & lmask;

  // Lowest-set searches
  always_comb begin
    first_pg = '0;
    next_pg  = '0;
    claim_pg = '0;
    for (int i = PAGES - 1; i >= 0; i--) begin
      if (avail_now[i]) first_pg = PAGE_W'(i);
      if (avail_q[i])   next_pg  = PAGE_W'(i);
      if (unclaimed[i]) claim_pg = PAGE_W'(i);
    end
  end

  always_comb begin
    free_blk = '0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (free_bits[i]) free_blk = BLK_W'(i);
    end
  end

  assign too_large = (req_size_i > block_size_i) || (req_align_i > block_size_i);
  assign bad_index = ({1'b0, free_page_i} >= (PAGE_W + 1)'(PAGES)) ||
                     ({1'b0, free_block_i} >= nblk_i);

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    rej_d         = rej_q;
    page_d        = page_q;
    blk_d         = blk_q;
    avail_d       = avail_q;
    in_use_d      = in_use_q;
    full_d        = full_q;
    mem_ctl_o     = '0;
    mem_wr_data_o = '0;
    res_valid_o   = 1'b0;
    res_o         = '0;
    new_word      = '0;
    blk_bit       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EVAL;
          page_d  = free_page_i;
          blk_d   = free_block_i;
          if (cmd_i == CMD_FREE) begin
            if (bad_index) begin
              op_d  = OP_REJECT;
              rej_d = ST_BAD_INDEX;
            end else begin
              op_d              = OP_FREE;
              mem_ctl_o.rd_en   = 1'b1;
              mem_ctl_o.rd_addr = free_page_i;
            end
          end else if (too_large) begin
            op_d  = OP_REJECT;
            rej_d = ST_TOO_LARGE;
          end else if (|avail_now) begin
            op_d              = OP_SCAN;
            page_d            = first_pg;
            avail_d           = avail_now & ~(PAGES'(1) << first_pg[PIDX_W-1:0]);
            mem_ctl_o.rd_en   = 1'b1;
            mem_ctl_o.rd_addr = first_pg;
          end else begin
            op_d = OP_CLAIM;
          end
        end
      end

      S_EVAL: begin
        unique case (op_q)
          OP_REJECT: begin
            if (out_ready_i) begin
              res_valid_o = 1'b1;
              res_o.status = rej_q;
              state_d     = S_IDLE;
            end
          end

          OP_SCAN: begin
            if (|free_bits) begin
              blk_bit  = MAX_BLOCKS'(1) << free_blk;
              new_word = mem_rd_data_i | blk_bit;
              if (out_ready_i) begin
                mem_ctl_o.wr_en   = 1'b1;
                mem_ctl_o.wr_addr = page_q;
                mem_wr_data_o     = new_word;
                if ((new_word & lmask) == lmask) begin
                  full_d[page_q[PIDX_W-1:0]] = 1'b1;
                end
                res_valid_o       = 1'b1;
                res_o.grant_page  = page_q;
                res_o.grant_block = free_blk;
                state_d           = S_IDLE;
              end
            end else if (|avail_q) begin
              // Stale page: no free block below the current count; try the next one
              page_d            = next_pg;
              avail_d           = avail_q & ~(PAGES'(1) << next_pg[PIDX_W-1:0]);
              mem_ctl_o.rd_en   = 1'b1;
              mem_ctl_o.rd_addr = next_pg;
            end else begin
              op_d = OP_CLAIM;
            end
          end

          OP_CLAIM: begin
            if (out_ready_i) begin
              res_valid_o = 1'b1;
              state_d     = S_IDLE;
              if (|unclaimed) begin
                // An unclaimed page holds an all-zero word
                mem_ctl_o.wr_en    = 1'b1;
                mem_ctl_o.wr_addr  = claim_pg;
                mem_wr_data_o      = MAX_BLOCKS'(1);
                in_use_d[claim_pg[PIDX_W-1:0]] = 1'b1;
                if (nblk_i == NBLK_W'(1)) begin
                  full_d[claim_pg[PIDX_W-1:0]] = 1'b1;
                end
                res_o.grant_page   = claim_pg;
                res_o.page_claimed = 1'b1;
              end else begin
                res_o.status = ST_NO_SPACE;
              end
            end
          end

          OP_FREE: begin
            blk_bit  = MAX_BLOCKS'(1) << blk_q;
            new_word = mem_rd_data_i & ~blk_bit;
            if (out_ready_i) begin
              res_valid_o = 1'b1;
              state_d     = S_IDLE;
              if ((mem_rd_data_i & blk_bit) == '0) begin
                res_o.status = ST_ALREADY_FREE;
              end else begin
                mem_ctl_o.wr_en   = 1'b1;
                mem_ctl_o.wr_addr = page_q;
                mem_wr_data_o     = new_word;
                full_d[page_q[PIDX_W-1:0]] = 1'b0;
              end
            end
          end

          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= OP_REJECT;
      rej_q    <= ST_OK;
      avail_q  <= '0;
      in_use_q <= '0;
      full_q   <= '0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      rej_q    <= rej_d;
      avail_q  <= avail_d;
      in_use_q <= in_use_d;
      full_q   <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
    blk_q  <= blk_d;
  end

endmodule

`default_nettype wire

/* hw/rtl/two_level_bitmap_block_allocator_unit.sv */
`default_nettype none

// Two-level bitmap block allocator. An allocate takes the lowest free block of the
// lowest claimed page that is not marked full, or else claims the lowest unclaimed
// page and grants its block 0; a free clears one block bit and the page's full mark.
// Page-claimed and page-full summaries sit in flops; the per-page block words sit in
// a single-port-read memory with registered read data that an item reads, modifies
// and writes back. An item is accepted, then evaluated and written back; each
// claimed page skipped because it has no free block below the current
// blocks_per_page adds a word read, and falling through to a page claim after
// such a scan adds another step. One item is in work at a time; the result
// register lets the next item be accepted while a result waits. Block words come
// out of reset as zero through per-page written marks, so there is no clearing pass.
// Write configuration only while the block is idle.
module two_level_bitmap_block_allocator_unit
  import tlba_pkg::*;
#(
  parameter int unsigned PAGES      = PAGES_DEFAULT,
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEFAULT
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              cmd_i,
  input  wire logic [SIZE_W-1:0] req_size_i,
  input  wire logic [SIZE_W-1:0] req_align_i,
  input  wire logic [PAGE_W-1:0] free_page_i,
  input  wire logic [BLK_W-1:0]  free_block_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [2:0]             status_o,
  output logic [PAGE_W-1:0]      grant_page_o,
  output logic [BLK_W-1:0]       grant_block_o,
  output logic                   page_claimed_o
);

  logic [NBLK_W-1:0] bpp_q;
  logic [SIZE_W-1:0] bsize_q;
  logic [NBLK_W-1:0] nblk;
  logic              out_valid_q;
  res_t              out_res_q;
  logic              out_ready;
  logic              res_valid;
  res_t              res;
  mem_ctl_t          mem_ctl;
  logic [MAX_BLOCKS-1:0] mem_wr_data;
  logic [MAX_BLOCKS-1:0] mem_rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q   <= BPP_RESET;
      bsize_q <= BSIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BLOCKS_PER_PAGE: bpp_q   <= cfg_wdata_i[NBLK_W-1:0];
        CFG_BLOCK_SIZE:      bsize_q <= cfg_wdata_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero acts as one, anything above the word width as the word width
  always_comb begin
    priority if (bpp_q == '0) begin
      nblk = NBLK_W'(1);
    end else if (bpp_q > NBLK_W'(MAX_BLOCKS)) begin
      nblk = NBLK_W'(MAX_BLOCKS);
    end else begin
      nblk = bpp_q;
    end
  end

  assign out_ready = !out_valid_q || !out_stall_i;

  tlba_ctrl #(
    .PAGES      (PAGES),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .req_size_i    (req_size_i),
    .req_align_i   (req_align_i),
    .free_page_i   (free_page_i),
    .free_block_i  (free_block_i),
    .nblk_i        (nblk),
    .block_size_i  (bsize_q),
    .out_ready_i   (out_ready),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .mem_ctl_o     (mem_ctl),
    .mem_wr_data_o (mem_wr_data),
    .mem_rd_data_i (mem_rd_data)
  );

  tlba_map_mem #(
    .PAGES      (PAGES),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_map_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .wr_data_i (mem_wr_data),
    .rd_data_o (mem_rd_data)
  );

  // Result register: load on a new result, drop after the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && out_ready) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_res_q.status;
  assign grant_page_o   = out_res_q.grant_page;
  assign grant_block_o  = out_res_q.grant_block;
  assign page_claimed_o = out_res_q.page_claimed;

`ifndef SYNTH
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_ctl.rd_en && mem_ctl.wr_en))
    else $error("page word read and write issued in the same cycle");

  a_res_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> out_ready)
    else $error("result produced while the result register is occupied");

  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |->
      (grant_page_o == '0 && grant_block_o == '0 && !page_claimed_o))
    else $error("failed request carries a grant");

  a_claim_block0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && page_claimed_o) |-> (grant_block_o == '0 && status_o == ST_OK))
    else $error("page claim did not grant block zero");
`endif

endmodule

`default_nettype wire
